### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define CHK_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

### hdl/stmds_pkg.sv
// types and constants of the stepper motor drive sequencer
package stmds_pkg;

    // request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_TURN   = 3'd1;
    localparam logic [2:0] REQ_MOVE   = 3'd2;
    localparam logic [2:0] REQ_GO     = 3'd3;
    localparam logic [2:0] REQ_ROTATE = 3'd4;
    localparam logic [2:0] REQ_STOP   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_DRIVER_KIND   = 2'd0;
    localparam logic [1:0] CFG_STEPS_PER_REV = 2'd1;
    localparam logic [1:0] CFG_MOVE_FORWARD  = 2'd2;
    localparam logic [1:0] CFG_HOLD_ON_STOP  = 2'd3;

    localparam logic [7:0]  SPEED_MAX       = 8'd100;
    localparam logic [12:0] STEPS_REV_RESET = 13'd200;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TURN,
        MODE_MOVE,
        MODE_GO,
        MODE_RELEASE
    } t_mode;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] amount;
        logic [7:0]  speed;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pin_levels;
        logic       busy_res;
        logic       accepted;
    } t_out_item;

    typedef struct packed {
        logic        driver_kind;
        logic [12:0] steps_per_rev;
        logic        move_forward;
        logic        hold_on_stop;
    } t_cfg;

    // request after the arithmetic stages, limit already resolved
    typedef struct packed {
        logic        valid;
        logic [2:0]  req_type;
        logic [7:0]  speed;
        logic [27:0] limit;
    } t_job;

    // unipolar half-step coil pattern, bit0 = pin one
    localparam logic [3:0] HALF_STEP_PINS [8] = '{
        4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
    };

endpackage

### hdl/stmds_cfg.sv
// configuration register bank
module stmds_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    output stmds_pkg::t_cfg     o_cfg
);

    stmds_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.driver_kind   <= 1'b0;
            r_cfg.steps_per_rev <= stmds_pkg::STEPS_REV_RESET;
            r_cfg.move_forward  <= 1'b1;
            r_cfg.hold_on_stop  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stmds_pkg::CFG_DRIVER_KIND:   r_cfg.driver_kind   <= i_cfg_data[0];
                stmds_pkg::CFG_STEPS_PER_REV: r_cfg.steps_per_rev <= i_cfg_data;
                stmds_pkg::CFG_MOVE_FORWARD:  r_cfg.move_forward  <= i_cfg_data[0];
                stmds_pkg::CFG_HOLD_ON_STOP:  r_cfg.hold_on_stop  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/stmds_prep.sv
// input register and arithmetic stages that resolve a command's step or time limit
module stmds_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  stmds_pkg::t_in_item i_item,
    input  logic [12:0]         i_steps_per_rev,
    output stmds_pkg::t_job     o_job
);

    // floor(x / 45) = (x * DIV45_RECIP) >> 32 for x below 2^26
    localparam logic [26:0] DIV45_RECIP = 27'd95443718;

    logic                r_s1_valid;
    stmds_pkg::t_in_item r_s1_item;
    logic [25:0]         r_s1_ms;
    logic [28:0]         r_s1_prod;
    stmds_pkg::t_job     r_job;

    logic [25:0] n_s1_ms;
    logic [28:0] n_s1_prod;
    logic [52:0] quot_full;
    logic [20:0] rot_steps;
    logic [27:0] n_limit;

    assign n_s1_ms   = 26'(i_item.amount) * 26'd1000;
    assign n_s1_prod = 29'(i_steps_per_rev) * 29'(i_item.amount);

    // divide by 360 as a shift by 3 then a divide by 45
    assign quot_full = 53'(r_s1_prod[28:3]) * 53'(DIV45_RECIP);
    assign rot_steps = quot_full[52:32];

    always_comb begin
        case (r_s1_item.req_type) inside
            stmds_pkg::REQ_TURN:   n_limit = 28'(r_s1_item.amount);
            stmds_pkg::REQ_MOVE:   n_limit = 28'(r_s1_ms);
            stmds_pkg::REQ_ROTATE: n_limit = 28'(rot_steps);
            default:               n_limit = 28'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_job.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid     <= i_valid;
            r_job.valid    <= r_s1_valid;
            r_s1_item      <= i_item;
            r_s1_ms        <= n_s1_ms;
            r_s1_prod      <= n_s1_prod;
            r_job.req_type <= r_s1_item.req_type;
            r_job.speed    <= r_s1_item.speed;
            r_job.limit    <= n_limit;
        end
    end

    assign o_job = r_job;

endmodule

### hdl/stmds_core.sv
// motion state, step sequencing and pin drive
module stmds_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stmds_pkg::t_cfg      i_cfg,
    input  stmds_pkg::t_job      i_job,
    input  logic                 i_fire,
    output stmds_pkg::t_out_item o_result
);

    localparam logic [25:0] ELAPSED_MAX = 26'h3FFFFFF;

    logic [2:0]       r_coil_phase,      n_coil_phase;
    stmds_pkg::t_mode r_run_mode,        n_run_mode;
    logic [27:0]      r_steps_remaining, n_steps_remaining;
    logic [20:0]      r_wait_ticks,      n_wait_ticks;
    logic [25:0]      r_elapsed_ticks,   n_elapsed_ticks;
    logic             r_pulse_phase,     n_pulse_phase;
    logic [6:0]       r_speed_held,      n_speed_held;
    logic [3:0]       r_pin_state,       n_pin_state;

    logic        is_cmd;
    logic        is_start;
    logic [6:0]  spd_use;
    logic [6:0]  slow;
    logic [20:0] gap_turn;
    logic [20:0] gap_ms;
    logic        taken;
    logic        do_bound;
    logic        do_step;
    logic        do_off;

    assign is_cmd = (i_job.req_type == stmds_pkg::REQ_TURN
                  || i_job.req_type == stmds_pkg::REQ_MOVE
                  || i_job.req_type == stmds_pkg::REQ_GO
                  || i_job.req_type == stmds_pkg::REQ_ROTATE)
                  && (i_job.speed <= stmds_pkg::SPEED_MAX);
    assign is_start = is_cmd && (i_job.speed != 8'd0);

    // a starting command brings its own speed into the first gap
    assign spd_use  = is_start ? i_job.speed[6:0] : r_speed_held;
    assign slow     = (spd_use > 7'd100) ? 7'd0 : 7'd100 - spd_use;
    assign gap_turn = 21'(slow) * 21'd1000;
    assign gap_ms   = 21'(slow) * 21'd10000 + 21'd1000;

    always_comb begin
        n_coil_phase      = r_coil_phase;
        n_run_mode        = r_run_mode;
        n_steps_remaining = r_steps_remaining;
        n_wait_ticks      = r_wait_ticks;
        n_elapsed_ticks   = r_elapsed_ticks;
        n_pulse_phase     = r_pulse_phase;
        n_speed_held      = r_speed_held;
        n_pin_state       = r_pin_state;
        taken             = 1'b0;
        do_bound          = 1'b0;
        do_step           = 1'b0;
        do_off            = 1'b0;

        if (i_fire) begin
            case (i_job.req_type) inside
                stmds_pkg::REQ_TICK: begin
                    if (r_run_mode == stmds_pkg::MODE_RELEASE) begin
                        // torque release countdown after a bipolar stop
                        if (r_wait_ticks <= 21'd1) begin
                            n_wait_ticks   = 21'd0;
                            n_pin_state[2] = 1'b1;
                            n_run_mode     = stmds_pkg::MODE_IDLE;
                        end else begin
                            n_wait_ticks = r_wait_ticks - 21'd1;
                        end
                    end else if (r_run_mode != stmds_pkg::MODE_IDLE) begin
                        if (r_elapsed_ticks != ELAPSED_MAX) begin
                            n_elapsed_ticks = r_elapsed_ticks + 26'd1;
                        end
                        if (r_wait_ticks > 21'd1) begin
                            n_wait_ticks = r_wait_ticks - 21'd1;
                        end else begin
                            n_wait_ticks = 21'd0;
                            if (r_pulse_phase) begin
                                // end of the step pulse, then the low gap
                                n_pin_state[0] = 1'b0;
                                n_pulse_phase  = 1'b0;
                                if (r_run_mode == stmds_pkg::MODE_TURN) begin
                                    n_wait_ticks = 21'd10 + gap_turn;
                                end else begin
                                    n_wait_ticks = 21'd10 + gap_ms;
                                end
                            end else begin
                                do_bound = 1'b1;
                            end
                        end
                    end
                end
                stmds_pkg::REQ_STOP: begin
                    taken  = 1'b1;
                    do_off = 1'b1;
                end
                [stmds_pkg::REQ_TURN:stmds_pkg::REQ_ROTATE]: begin
                    if (is_cmd) begin
                        taken = 1'b1;
                        if (!is_start) begin
                            do_off = 1'b1;
                        end else begin
                            n_speed_held      = i_job.speed[6:0];
                            n_elapsed_ticks   = 26'd0;
                            n_steps_remaining = i_job.limit;
                            do_bound          = 1'b1;
                            if (i_job.req_type == stmds_pkg::REQ_MOVE) begin
                                n_run_mode = stmds_pkg::MODE_MOVE;
                            end else if (i_job.req_type == stmds_pkg::REQ_GO) begin
                                n_run_mode = stmds_pkg::MODE_GO;
                            end else begin
                                n_run_mode = stmds_pkg::MODE_TURN;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_bound) begin
            if ((n_run_mode == stmds_pkg::MODE_TURN && n_steps_remaining == 28'd0)
                || (n_run_mode == stmds_pkg::MODE_MOVE
                    && {2'b00, n_elapsed_ticks} >= n_steps_remaining)) begin
                do_off = 1'b1;
            end else begin
                do_step = 1'b1;
            end
        end

        if (do_step) begin
            if (i_cfg.driver_kind) begin
                n_coil_phase  = i_cfg.move_forward ? r_coil_phase + 3'd1
                                                   : r_coil_phase - 3'd1;
                n_pin_state   = stmds_pkg::HALF_STEP_PINS[n_coil_phase];
                n_pulse_phase = 1'b0;
                if (n_run_mode == stmds_pkg::MODE_TURN) begin
                    n_wait_ticks = 21'd1000 + gap_turn;
                end else if (n_run_mode == stmds_pkg::MODE_MOVE) begin
                    n_wait_ticks = 21'd1000 + gap_ms;
                end else begin
                    n_wait_ticks = gap_ms;
                end
            end else begin
                // step high, dir from config, enable low, pin four untouched
                n_pin_state   = {n_pin_state[3], 1'b0, i_cfg.move_forward, 1'b1};
                n_pulse_phase = 1'b1;
                n_wait_ticks  = 21'd10;
            end
            if (n_run_mode == stmds_pkg::MODE_TURN && n_steps_remaining != 28'd0) begin
                n_steps_remaining = n_steps_remaining - 28'd1;
            end
        end

        if (do_off) begin
            n_pin_state   = n_pin_state & 4'h4;
            n_pulse_phase = 1'b0;
            if (i_cfg.driver_kind || i_cfg.hold_on_stop) begin
                n_pin_state  = 4'h0;
                n_run_mode   = stmds_pkg::MODE_IDLE;
                n_wait_ticks = 21'd0;
            end else begin
                n_run_mode   = stmds_pkg::MODE_RELEASE;
                n_wait_ticks = 21'd100;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil_phase      <= 3'd0;
            r_run_mode        <= stmds_pkg::MODE_IDLE;
            r_steps_remaining <= 28'd0;
            r_wait_ticks      <= 21'd0;
            r_elapsed_ticks   <= 26'd0;
            r_pulse_phase     <= 1'b0;
            r_speed_held      <= 7'd0;
            r_pin_state       <= 4'h0;
        end else begin
            r_coil_phase      <= n_coil_phase;
            r_run_mode        <= n_run_mode;
            r_steps_remaining <= n_steps_remaining;
            r_wait_ticks      <= n_wait_ticks;
            r_elapsed_ticks   <= n_elapsed_ticks;
            r_pulse_phase     <= n_pulse_phase;
            r_speed_held      <= n_speed_held;
            r_pin_state       <= n_pin_state;
        end
    end

    assign o_result.pin_levels = n_pin_state;
    assign o_result.busy_res   = (n_run_mode == stmds_pkg::MODE_TURN)
                              || (n_run_mode == stmds_pkg::MODE_MOVE)
                              || (n_run_mode == stmds_pkg::MODE_GO);
    assign o_result.accepted   = taken;

endmodule

### hdl/stepper_motor_drive_sequencer.sv
// top level of the stepper motor drive sequencer
// Input channel: i_in_valid / o_in_stall carry one item per transfer, either a
// one-microsecond tick or a motion command (turn, move, go, rotate, stop).
// Output channel: o_out_valid / i_out_stall carry one result per input item,
// in order: pin levels after the item, busy flag and command-taken flag.
// Config channel: i_cfg_valid / o_cfg_ready write one register per transfer;
// o_cfg_ready is always high. Write only while no item is in flight.
// Path: a result passes the input register, the divide-by-360 multiply stage
// and the state update into the output register. Throughput: one item per
// cycle while o_in_stall is low.
// When the receiver stalls, the output register holds its result and one
// more result lands in a skid register; o_in_stall then rises until the skid
// register drains.
// Reset (i_rst_n low, synchronous) empties the pipeline, sets the motor idle
// with all pins low, and loads the config defaults.
module stepper_motor_drive_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stmds_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stmds_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data
);

    stmds_pkg::t_cfg      cfg;
    stmds_pkg::t_job      job;
    stmds_pkg::t_out_item result;
    logic                 en;
    logic                 fire;
    logic                 out_take;

    logic                 r_out_valid;
    stmds_pkg::t_out_item r_out_data;
    logic                 r_skid_valid;
    stmds_pkg::t_out_item r_skid_data;

    assign en       = !r_skid_valid;
    assign fire     = en && job.valid;
    assign out_take = r_out_valid && !i_out_stall;

    stmds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    stmds_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_in_valid),
        .i_item          (i_in_data),
        .i_steps_per_rev (cfg.steps_per_rev),
        .o_job           (job)
    );

    stmds_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_job    (job),
        .i_fire   (fire),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= fire;
        end else if (fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || out_take) begin
            if (fire) begin
                r_out_data <= result;
            end
        end else if (fire) begin
            // output still waiting for its transfer
            r_skid_data <= result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

### hdl/stmds_chk.sv
// port-level checker for the stepper motor drive sequencer, with its bind
`include "assert_macros.svh"

module stmds_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input stmds_pkg::t_out_item o_out_data
);

    `CHK_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    `CHK_ASSERT(a_stall_cause, $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall), "input stall without a stalled output")

    `CHK_NEVER(a_stall_no_out, o_in_stall && !o_out_valid, "input stalled with output register empty")

    `CHK_ASSERT(a_off_pins_low, o_out_valid && o_out_data.accepted && !o_out_data.busy_res |-> o_out_data.pin_levels[0] == 1'b0 && o_out_data.pin_levels[1] == 1'b0 && o_out_data.pin_levels[3] == 1'b0, "pins left high after switch off")

endmodule

bind stepper_motor_drive_sequencer stmds_chk u_chk (.*);

### sim/stmds_scoreboard.sv
// scoreboard for the stepper motor drive sequencer: predicts every result and compares
module stmds_scoreboard
    import stmds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TICKS_PER_MS  = 1000;
    localparam int unsigned DEG_PER_REV   = 360;
    localparam int unsigned RELEASE_TICKS = 100;
    localparam int unsigned PULSE_TICKS   = 10;
    localparam logic [3:0]  PIN_STEP      = 4'h1;
    localparam logic [3:0]  PIN_DIR       = 4'h2;
    localparam logic [3:0]  PIN_ENABLE    = 4'h4;
    localparam logic [3:0]  PIN_FOUR      = 4'h8;

    t_cfg        cfg_q;
    logic [2:0]  coil_idx;
    t_mode       mode_q;
    logic [27:0] step_budget;   // steps left for turn, tick limit for move
    logic [20:0] gap_left;
    logic [25:0] run_time;
    logic [1:0]  pulse_q;
    logic [6:0]  speed_q;
    logic [3:0]  pins_q;
    t_out_item   pin_results_due[$];

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic int unsigned slowness();
        return (speed_q > 7'd100) ? 0 : 100 - 32'(speed_q);
    endfunction

    function automatic int unsigned step_gap_ms();
        return (slowness() * 10 + 1) * TICKS_PER_MS;
    endfunction

    function automatic void motor_off();
        pins_q  = pins_q & PIN_ENABLE;
        pulse_q = 2'd0;
        if (cfg_q.driver_kind || cfg_q.hold_on_stop) begin
            pins_q   = 4'h0;
            mode_q   = MODE_IDLE;
            gap_left = '0;
        end else begin
            // bipolar without hold: enable goes high once the release delay ends
            mode_q   = MODE_RELEASE;
            gap_left = 21'(RELEASE_TICKS);
        end
    endfunction

    function automatic void next_step();
        if (cfg_q.driver_kind) begin
            coil_idx = cfg_q.move_forward ? coil_idx + 3'd1 : coil_idx - 3'd1;
            pins_q   = HALF_STEP_PINS[coil_idx];
            pulse_q  = 2'd0;
            case (mode_q)
                MODE_TURN: gap_left = 21'(TICKS_PER_MS + slowness() * TICKS_PER_MS);
                MODE_MOVE: gap_left = 21'(TICKS_PER_MS + step_gap_ms());
                default:   gap_left = 21'(step_gap_ms());
            endcase
        end else begin
            // pin four keeps whatever a unipolar step left there
            pins_q   = (pins_q & PIN_FOUR) | (cfg_q.move_forward ? PIN_DIR : 4'h0) | PIN_STEP;
            pulse_q  = 2'd1;
            gap_left = 21'(PULSE_TICKS);
        end
        if (mode_q == MODE_TURN && step_budget != 0)
            step_budget--;
    endfunction

    function automatic void step_or_finish();
        if (mode_q == MODE_TURN && step_budget == 0)
            motor_off();
        else if (mode_q == MODE_MOVE && {2'b00, run_time} >= step_budget)
            motor_off();
        else
            next_step();
    endfunction

    function automatic void begin_motion(input t_mode m, input int unsigned lim,
                                         input logic [7:0] spd);
        speed_q     = spd[6:0];
        mode_q      = m;
        run_time    = '0;
        step_budget = lim[27:0];
        step_or_finish();
    endfunction

    function automatic void one_tick();
        if (mode_q == MODE_IDLE)
            return;
        if (mode_q == MODE_RELEASE) begin
            if (gap_left <= 1) begin
                gap_left = '0;
                pins_q   = pins_q | PIN_ENABLE;
                mode_q   = MODE_IDLE;
            end else begin
                gap_left--;
            end
            return;
        end
        if (run_time != '1)
            run_time++;
        if (gap_left > 1) begin
            gap_left--;
            return;
        end
        gap_left = '0;
        if (pulse_q == 2'd1) begin
            // end of the step pulse, then the gap before the next step
            pins_q  = pins_q & ~PIN_STEP;
            pulse_q = 2'd0;
            if (mode_q == MODE_TURN)
                gap_left = 21'(PULSE_TICKS + slowness() * TICKS_PER_MS);
            else
                gap_left = 21'(PULSE_TICKS + step_gap_ms());
        end else begin
            step_or_finish();
        end
    endfunction

    function automatic t_out_item advance_motor(input t_in_item it);
        t_out_item   res;
        logic        taken;
        int unsigned lim;
        taken = 1'b0;
        if (it.req_type == REQ_TICK) begin
            one_tick();
        end else if (it.req_type == REQ_STOP) begin
            taken = 1'b1;
            motor_off();
        end else if (it.req_type <= REQ_ROTATE && it.speed <= SPEED_MAX) begin
            taken = 1'b1;
            if (it.speed == 8'd0) begin
                motor_off();
            end else begin
                case (it.req_type)
                    REQ_TURN: begin_motion(MODE_TURN, 32'(it.amount), it.speed);
                    REQ_MOVE: begin
                        lim = 32'(it.amount);
                        begin_motion(MODE_MOVE, lim * TICKS_PER_MS, it.speed);
                    end
                    REQ_GO:   begin_motion(MODE_GO, 0, it.speed);
                    default: begin
                        lim = 32'(cfg_q.steps_per_rev);
                        lim = (lim * 32'(it.amount)) / DEG_PER_REV;
                        begin_motion(MODE_TURN, lim, it.speed);
                    end
                endcase
            end
        end
        res.pin_levels = pins_q;
        res.busy_res   = (mode_q == MODE_TURN || mode_q == MODE_MOVE || mode_q == MODE_GO);
        res.accepted   = taken;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_q       = '{driver_kind: 1'b0, steps_per_rev: STEPS_REV_RESET,
                            move_forward: 1'b1, hold_on_stop: 1'b0};
            coil_idx    = '0;
            mode_q      = MODE_IDLE;
            step_budget = '0;
            gap_left    = '0;
            run_time    = '0;
            pulse_q     = '0;
            speed_q     = '0;
            pins_q      = '0;
            pin_results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DRIVER_KIND:   cfg_q.driver_kind   = i_cfg_data[0];
                    CFG_STEPS_PER_REV: cfg_q.steps_per_rev = i_cfg_data;
                    CFG_MOVE_FORWARD:  cfg_q.move_forward  = i_cfg_data[0];
                    CFG_HOLD_ON_STOP:  cfg_q.hold_on_stop  = i_cfg_data[0];
                    default: ;
                endcase
            end
            // compare before pushing so a result can never match its own transfer
            if (i_out_valid && !i_out_stall) begin
                if (pin_results_due.size() == 0) begin
                    report($sformatf("result %h with no item waiting", i_out_data));
                end else begin
                    want = pin_results_due.pop_front();
                    if (i_out_data.pin_levels !== want.pin_levels)
                        report($sformatf("pin_levels got %h expected %h",
                                         i_out_data.pin_levels, want.pin_levels));
                    if (i_out_data.busy_res !== want.busy_res)
                        report($sformatf("busy_res got %b expected %b",
                                         i_out_data.busy_res, want.busy_res));
                    if (i_out_data.accepted !== want.accepted)
                        report($sformatf("accepted got %b expected %b",
                                         i_out_data.accepted, want.accepted));
                end
            end
            if (i_in_valid && !i_in_stall)
                pin_results_due.push_back(advance_motor(i_in_data));
        end
        o_pending = pin_results_due.size();
    end

endmodule

### sim/tb_stepper_motor_drive_sequencer.sv
// testbench top for the stepper motor drive sequencer: stimulus, idling and verdict
module tb_stepper_motor_drive_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import stmds_pkg::*;

    // request codes the block must ignore
    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;
    localparam int         NUM_PHASES   = 6;
    localparam int         SEGMENTS     = 6;
    localparam int         LONG_HOLD    = 60;
    localparam t_cfg PHASE_CFG [NUM_PHASES] = '{
        '{1'b0, 13'd200,  1'b1, 1'b0},
        '{1'b1, 13'd4096, 1'b0, 1'b0},
        '{1'b0, 13'd1,    1'b0, 1'b1},
        '{1'b1, 13'd0,    1'b1, 1'b1},
        '{1'b0, 13'd8191, 1'b1, 1'b0},
        '{1'b1, 13'd200,  1'b1, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [12:0] i_cfg_data;

    int error_count;
    int results_due;
    bit quiet;
    bit hold_out;

    stepper_motor_drive_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    stmds_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (error_count),
        .o_pending    (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [2:0] req, input logic [15:0] amt,
                             input logic [7:0] spd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{req_type: req, amount: amt, speed: spd};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_item(REQ_TICK, 16'($urandom), 8'($urandom));
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
    endtask

    task automatic random_segment();
        logic [2:0]  req;
        logic [15:0] amt;
        logic [7:0]  spd;
        int          pick;
        quiet = ($urandom_range(0, 4) == 0);
        pick  = $urandom_range(0, 19);
        if (pick < 10)
            spd = SPEED_MAX;
        else if (pick < 13)
            spd = 8'd0;
        else if (pick < 15)
            spd = 8'($urandom_range(101, 255));
        else
            spd = 8'($urandom_range(1, 100));
        amt  = 16'($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            req = REQ_TURN;
        end else if (pick < 40) begin
            req = REQ_MOVE;
            amt = 16'($urandom_range(0, 1));
        end else if (pick < 50) begin
            req = REQ_GO;
        end else if (pick < 70) begin
            req = REQ_ROTATE;
            amt = 16'($urandom_range(0, 12));
        end else if (pick < 80) begin
            req = REQ_STOP;
        end else if (pick < 85) begin
            req = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
        end else begin
            // noise over the whole item
            req = 3'($urandom_range(0, 7));
            spd = 8'($urandom);
        end
        if ($urandom_range(0, 9) == 0)
            amt = 16'($urandom);
        send_item(req, amt, spd);
        pick = $urandom_range(0, 19);
        if (pick < 14)
            tick_run($urandom_range(0, 6));
        else if (pick < 19)
            tick_run($urandom_range(7, 30));
        else
            tick_run($urandom_range(95, 125));   // long enough to see the enable release
    endtask

    // receiver: random stall before each result, plus one long hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                n = LONG_HOLD;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 4);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        hold_out    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset configuration
        send_item(REQ_TICK, 16'hFFFF, 8'hFF);
        send_item(REQ_STOP, 16'hFFFF, 8'hFF);       // stop ignores its fields
        send_item(REQ_UNUSED_A, 16'hFFFF, 8'hFF);
        send_item(REQ_UNUSED_B, 16'h0000, 8'h00);
        send_item(REQ_TURN, 16'd3, 8'd101);         // too fast, ignored
        send_item(REQ_ROTATE, 16'd90, 8'hFF);
        send_item(REQ_TURN, 16'd5, 8'd0);           // speed zero switches off
        send_item(REQ_TURN, 16'd0, SPEED_MAX);      // zero steps
        send_item(REQ_MOVE, 16'd0, 8'd50);          // zero milliseconds
        send_item(REQ_ROTATE, 16'd1, SPEED_MAX);    // rounds down to zero steps
        send_item(REQ_GO, 16'hFFFF, 8'd1);
        tick_run(3);
        send_item(REQ_TURN, 16'd2, SPEED_MAX);      // replaces the running go
        tick_run(4);
        send_item(REQ_STOP, 16'd0, 8'd0);
        tick_run(2);
        send_item(REQ_ROTATE, 16'd360, SPEED_MAX);  // cancels the pending release
        send_item(REQ_MOVE, 16'hFFFF, SPEED_MAX);
        send_item(REQ_TURN, 16'hFFFF, 8'd1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                // motor may still be running; only the pipeline has to be empty
                drain();
                put_reg(CFG_DRIVER_KIND,   {12'd0, PHASE_CFG[ph].driver_kind});
                put_reg(CFG_STEPS_PER_REV, PHASE_CFG[ph].steps_per_rev);
                put_reg(CFG_MOVE_FORWARD,  {12'd0, PHASE_CFG[ph].move_forward});
                put_reg(CFG_HOLD_ON_STOP,  {12'd0, PHASE_CFG[ph].hold_on_stop});
                i_cfg_valid <= 1'b0;
            end
            if (PHASE_CFG[ph].driver_kind) begin
                // first half step; the next phase may switch the kind mid-run
                send_item(REQ_TURN, 16'd2, SPEED_MAX);
                tick_run(5);
            end else begin
                // three pulses 20 ticks apart, the turn ends, then the release unless hold_on_stop is set
                send_item(REQ_TURN, 16'd3, SPEED_MAX);
                tick_run((ph == 0) ? 170 : 70);
            end
            if (ph == 1)
                hold_out = 1'b1;
            repeat (SEGMENTS) random_segment();
        end

        quiet = 1'b0;
        drain();
        repeat (6) @(negedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/stmds_pkg.sv
hdl/stmds_cfg.sv
hdl/stmds_prep.sv
hdl/stmds_core.sv
hdl/stepper_motor_drive_sequencer.sv
hdl/stmds_chk.sv
sim/stmds_scoreboard.sv
sim/tb_stepper_motor_drive_sequencer.sv
